// File: rtl/rpb_pkg.sv
`timescale 1ns / 1ps

package rpb_pkg;

   localparam int MAP_SLOTS = 32;
   localparam int SLOT_W    = 5;
   localparam int COUNT_W   = 6;
   localparam int RAND_W    = 15;
   localparam int KEY_W     = 12;
   localparam int STEP_W    = 4;
   localparam int ADDR_W    = 3;
   localparam int DATA_W    = 32;

   localparam logic [COUNT_W-1:0] TRACK_COUNT_RESET = 6'd32;
   localparam logic               REG_TRACK_COUNT   = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_SCAN,
      ST_DONE
   } rpb_state_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [SLOT_W-1:0] track;
      logic              last;
   } rpb_place_type;

endpackage

// File: rtl/rpb_core.sv
`timescale 1ns / 1ps

module rpb_core
   import rpb_pkg::*;
#(
   parameter int MAX_TRACKS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                restart,
   input  logic [COUNT_W-1:0]  track_count,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [RAND_W-1:0]   random_value,
   input  logic                out_free,
   output logic                place_valid,
   output rpb_place_type       place
);

   localparam int LIMIT = (MAX_TRACKS < MAP_SLOTS) ? MAX_TRACKS : MAP_SLOTS;

   rpb_state_type state_ff, state_in;

   logic [MAP_SLOTS-1:0] free_map_ff, free_map_in;
   logic [COUNT_W-1:0]   placed_count_ff, placed_count_in;
   logic [KEY_W-1:0]     val_ff, val_in;
   logic [COUNT_W-1:0]   rem_ff, rem_in;
   logic [COUNT_W-1:0]   div_ff, div_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [SLOT_W-1:0]    idx_ff, idx_in;

   logic [COUNT_W-1:0]   n_cur;
   logic [COUNT_W:0]     alu_a;
   logic [COUNT_W-1:0]   alu_b;
   logic [COUNT_W+1:0]   alu_diff;
   logic                 alu_borrow;
   logic                 slot_avail;
   logic                 accept;
   logic                 need_restart;
   logic [COUNT_W-1:0]   count_next;
   logic                 last;

   // effective entry count
   always_comb begin
      n_cur = (track_count == '0) ? COUNT_W'(1) : track_count;
      if (n_cur > COUNT_W'(LIMIT)) begin
         n_cur = COUNT_W'(LIMIT);
      end
   end

   // shared subtract unit
   always_comb begin
      if (state_ff == ST_DIV) begin
         alu_a = {rem_ff, val_ff[KEY_W-1]};
         alu_b = div_ff;
      end else begin
         alu_a = {1'b0, rem_ff};
         alu_b = COUNT_W'(1);
      end
      alu_diff   = {1'b0, alu_a} - {2'b00, alu_b};
      alu_borrow = alu_diff[COUNT_W+1];
   end

   assign slot_avail   = free_map_ff[idx_ff] && ({1'b0, idx_ff} < n_cur);
   assign accept       = req_valid && req_ready;
   assign need_restart = placed_count_ff >= n_cur;
   assign count_next   = placed_count_ff + COUNT_W'(1);
   assign last         = count_next >= n_cur;

   assign req_ready   = state_ff == ST_IDLE;
   assign place_valid = (state_ff == ST_DONE) && out_free;
   assign place.slot  = idx_ff;
   assign place.track = placed_count_ff[SLOT_W-1:0];
   assign place.last  = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_map_ff     <= '1;
         placed_count_ff <= '0;
      end else begin
         free_map_ff     <= free_map_in;
         placed_count_ff <= placed_count_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      step_ff <= step_in;
      idx_ff  <= idx_in;
   end

   always_comb begin
      state_in        = state_ff;
      free_map_in     = free_map_ff;
      placed_count_in = placed_count_ff;
      val_in          = val_ff;
      rem_in          = rem_ff;
      div_in          = div_ff;
      step_in         = step_ff;
      idx_in          = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               val_in  = random_value[KEY_W-1:0];
               rem_in  = '0;
               step_in = '0;
               idx_in  = '0;
               if (need_restart) begin
                  free_map_in     = '1;
                  placed_count_in = '0;
                  div_in          = n_cur;
               end else begin
                  div_in = n_cur - placed_count_ff;
               end
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = alu_borrow ? alu_a[COUNT_W-1:0] : alu_diff[COUNT_W-1:0];
            val_in = {val_ff[KEY_W-2:0], 1'b0};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(KEY_W - 1)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (slot_avail && rem_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               if (slot_avail) begin
                  rem_in = alu_diff[COUNT_W-1:0];
               end
               idx_in = idx_ff + SLOT_W'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               if (last) begin
                  free_map_in     = '1;
                  placed_count_in = '0;
               end else begin
                  free_map_in[idx_ff] = 1'b0;
                  placed_count_in     = count_next;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (restart) begin
         free_map_in     = '1;
         placed_count_in = '0;
      end
   end

   a_count_below_n: assert property (@(posedge clock) disable iff (reset)
      placed_count_ff < n_cur)
      else $error("placement count reached entry count");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < div_ff)
      else $error("partial remainder not reduced");

   a_div_to_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV && step_ff == STEP_W'(KEY_W - 1) |=> state_ff == ST_SCAN)
      else $error("modulo did not hand over to slot scan");

endmodule

// File: rtl/random_permutation_builder.sv
`timescale 1ns / 1ps
// req_ready is high only while idle; each req beat runs the 12-step serial
// modulo and then the one-slot-per-cycle scan through the free map, both on
// one subtractor, and no new beat is taken until its placement enters rsp
// reset: track_count 32, all slots free, no placements, rsp empty
// a track_count write also restarts the shuffle

module random_permutation_builder
   import rpb_pkg::*;
#(
   parameter int MAX_TRACKS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [RAND_W-1:0]   req_random_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic [SLOT_W-1:0]   rsp_track,
   output logic                rsp_last_of_shuffle,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [ADDR_W-1:0]   csr_paddr,
   input  logic [DATA_W-1:0]   csr_pwdata,
   output logic [DATA_W-1:0]   csr_prdata,
   output logic                csr_pready
);

   logic [COUNT_W-1:0] track_count_ff, track_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rpb_place_type      rsp_ff, rsp_in;

   logic               cfg_write;
   logic               out_free;
   logic               place_valid;
   rpb_place_type      place;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_TRACK_COUNT);
   assign csr_prdata = (csr_paddr[2] == REG_TRACK_COUNT)
                       ? {{(DATA_W-COUNT_W){1'b0}}, track_count_ff} : '0;

   assign out_free = !rsp_valid_ff || rsp_ready;

   rpb_core #(
      .MAX_TRACKS(MAX_TRACKS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .restart     (cfg_write),
      .track_count (track_count_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .random_value(req_random_value),
      .out_free    (out_free),
      .place_valid (place_valid),
      .place       (place)
   );

   always_comb begin
      track_count_in = cfg_write ? csr_pwdata[COUNT_W-1:0] : track_count_ff;
      rsp_in         = place_valid ? place : rsp_ff;
      rsp_valid_in   = place_valid || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         track_count_ff <= TRACK_COUNT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         track_count_ff <= track_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_slot            = rsp_ff.slot;
   assign rsp_track           = rsp_ff.track;
   assign rsp_last_of_shuffle = rsp_ff.last;

endmodule
